### design/ptfa_pkg.sv
// ----------------------------------------------------------------------------
// ptfa_pkg
// Shared field widths, command codes and status codes of the frame allocator.
// ----------------------------------------------------------------------------
package ptfa_pkg;

    localparam int FUNC_W   = 1;
    localparam int PID_W    = 3;
    localparam int AID_W    = 8;
    localparam int PAGE_W   = 7;
    localparam int PCNT_W   = 3;
    localparam int STATUS_W = 3;
    localparam int BLK_W    = 5;
    localparam int EVC_W    = 6;
    localparam int ASG_W    = 7;
    localparam int FLT_W    = 32;

    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [FUNC_W-1:0]   t_func;

    localparam t_func FUNC_ACCESS = 1'b0;
    localparam t_func FUNC_ALLOC  = 1'b1;

    localparam t_status ST_ALLOCATED = 3'd0;
    localparam t_status ST_HIT       = 3'd1;
    localparam t_status ST_FAULT     = 3'd2;
    localparam t_status ST_BAD_PROC  = 3'd3;
    localparam t_status ST_EXISTS    = 3'd4;
    localparam t_status ST_PARTIAL   = 3'd5;
    localparam t_status ST_NOT_OWNED = 3'd6;
    localparam t_status ST_TOO_LARGE = 3'd7;

    localparam logic [PCNT_W-1:0] PCNT_RESET = 3'd4;

endpackage

### design/page_table_frame_allocator_lru.sv
// ----------------------------------------------------------------------------
// page_table_frame_allocator_lru
// Page-table allocator with power-of-two frame blocks and LRU eviction.
// ----------------------------------------------------------------------------
// Sequence: a bad process goes straight to the result. Allocate scans the
//   in-use tables for the id, then the process table, one entry per cycle; a
//   fault scans the recency list, the process table, then frames one per
//   cycle, and each eviction shifts the list, so emptying it is the longest case.
// Throughput: one request at a time; the next is taken when the current one
//   has moved to the output register.
// Reset: clears control state, then a pass over MAX_PROCESSES*TABLE_ENTRIES
//   table entries marks every one unused; no request is taken meanwhile.
module page_table_frame_allocator_lru #(
    parameter int MAX_PROCESSES = 4,
    parameter int TABLE_ENTRIES = 64,
    parameter int FRAME_COUNT   = 32,
    parameter int ID_WIDTH      = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ptfa_pkg::PCNT_W-1:0]    i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [ptfa_pkg::FUNC_W-1:0]    i_func,
    input  logic [ptfa_pkg::PID_W-1:0]     i_process_id,
    input  logic [ptfa_pkg::AID_W-1:0]     i_alloc_id,
    input  logic [ptfa_pkg::PAGE_W-1:0]    i_page_count,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ptfa_pkg::STATUS_W-1:0]  o_status,
    output logic [ptfa_pkg::BLK_W-1:0]     o_block_start,
    output logic [ptfa_pkg::BLK_W-1:0]     o_block_end,
    output logic [ptfa_pkg::EVC_W-1:0]     o_evicted_count,
    output logic [ptfa_pkg::ASG_W-1:0]     o_pages_assigned,
    output logic [ptfa_pkg::FLT_W-1:0]     o_fault_total
);

    import ptfa_pkg::*;

    localparam int TBL  = MAX_PROCESSES * TABLE_ENTRIES;
    localparam int TW   = $clog2(TBL);
    localparam int FW   = $clog2(FRAME_COUNT);
    localparam int LNW  = $clog2(FRAME_COUNT + 1);
    localparam int NW   = $clog2(TABLE_ENTRIES + 1);
    localparam int VW   = NW + 1;
    localparam int CW   = ((VW > FW + 1) ? VW : FW + 1) + 1;
    localparam int PW   = ((TW > FW) ? TW : FW) + 1;
    localparam int KW   = ((NW > PAGE_W) ? NW : PAGE_W) + 1;
    localparam int PCW  = ($clog2(MAX_PROCESSES + 1) > PCNT_W) ?
                          $clog2(MAX_PROCESSES + 1) : PCNT_W;
    localparam int TEW  = ID_WIDTH + 1;
    localparam int LEW  = ID_WIDTH + 2 * FW;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EXIST = 4'd2;
    localparam logic [3:0] S_AFILL = 4'd3;
    localparam logic [3:0] S_LSRCH = 4'd4;
    localparam logic [3:0] S_SHIFT = 4'd5;
    localparam logic [3:0] S_COUNT = 4'd6;
    localparam logic [3:0] S_PREP  = 4'd7;
    localparam logic [3:0] S_FIND  = 4'd8;
    localparam logic [3:0] S_FILL  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]             r_state;
    logic [PCNT_W-1:0]      r_pcnt;
    logic [ID_WIDTH-1:0]    r_id;
    logic [TW-1:0]          r_base;
    logic [PW-1:0]          r_ptr;
    logic [PW-1:0]          r_end;
    logic [PW-1:0]          r_pidx;
    logic                   r_pend;
    logic [KW-1:0]          r_need;
    logic [NW-1:0]          r_n;
    logic [NW-1:0]          r_assigned;
    logic [VW-1:0]          r_vol;
    logic [CW-1:0]          r_bs;
    logic [CW-1:0]          r_f;
    logic                   r_evm;
    logic [LEW-1:0]         r_sv;
    logic [FRAME_COUNT-1:0] r_occ;
    logic [LNW-1:0]         r_len;
    logic [LNW-1:0]         r_evicted;
    logic [FLT_W-1:0]       r_faults;
    t_status                r_status;
    logic [FW-1:0]          r_bstart;
    logic [FW-1:0]          r_bend;
    logic                   r_o_valid;

    logic [PCW-1:0]         nproc;
    logic                   issue;
    logic                   scan_done;
    logic                   a_stop;
    logic                   a_claim;
    logic [KW-1:0]          n_need;
    logic [VW-1:0]          vol_c;
    logic [CW-1:0]          blk_last;
    logic [FW-1:0]          rng_lo;
    logic [FW-1:0]          rng_hi;
    logic [FRAME_COUNT-1:0] rng_mask;

    logic                   t_we;
    logic [TW-1:0]          t_waddr;
    logic [TEW-1:0]         t_wdata;
    logic [TW-1:0]          t_raddr;
    logic [TEW-1:0]         t_rdata;
    logic                   t_used;
    logic [ID_WIDTH-1:0]    t_owner;

    logic                   l_we;
    logic [FW-1:0]          l_waddr;
    logic [LEW-1:0]         l_wdata;
    logic [FW-1:0]          l_raddr;
    logic [LEW-1:0]         l_rdata;
    logic [ID_WIDTH-1:0]    l_id;
    logic [FW-1:0]          l_start;
    logic [FW-1:0]          l_end;

    ptfa_ram #(.WIDTH(TEW), .DEPTH(TBL)) u_table (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    ptfa_ram #(.WIDTH(LEW), .DEPTH(FRAME_COUNT)) u_list (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    assign t_used  = t_rdata[ID_WIDTH];
    assign t_owner = t_rdata[ID_WIDTH-1:0];
    assign l_id    = l_rdata[LEW-1 -: ID_WIDTH];
    assign l_start = l_rdata[2*FW-1 -: FW];
    assign l_end   = l_rdata[FW-1:0];

    assign nproc     = (PCW'(r_pcnt) > PCW'(MAX_PROCESSES)) ? PCW'(MAX_PROCESSES) :
                       PCW'(r_pcnt);
    assign issue     = (r_ptr < r_end);
    assign scan_done = !r_pend && !issue;
    assign blk_last  = r_bs + CW'(r_vol) - CW'(1);

    assign a_stop  = (r_need == '0) ||
                     (r_need > (KW'(TABLE_ENTRIES) - KW'(r_pidx)));
    assign a_claim = (r_state == S_AFILL) && r_pend && !a_stop && !t_used;
    assign n_need  = r_need - KW'(a_claim);

    always_comb begin
        vol_c = VW'(1);
        for (int k = 0; k < NW; k++) begin
            if (VW'(r_n) > (VW'(1) << k)) begin
                vol_c = VW'(1) << (k + 1);
            end
        end
    end

    always_comb begin
        if (r_state == S_FILL) begin
            rng_lo = FW'(r_bs);
            rng_hi = FW'(blk_last);
        end else begin
            rng_lo = l_start;
            rng_hi = l_end;
        end
        for (int f = 0; f < FRAME_COUNT; f++) begin
            rng_mask[f] = (FW'(f) >= rng_lo) && (FW'(f) <= rng_hi);
        end
    end

    always_comb begin
        t_we    = 1'b0;
        t_waddr = TW'(PW'(r_base) + r_pidx);
        t_wdata = {1'b1, r_id};
        t_raddr = TW'(PW'(r_base) + r_ptr);
        if (r_state == S_CLEAR) begin
            t_we    = 1'b1;
            t_waddr = TW'(r_ptr);
            t_wdata = '0;
        end else if (r_state == S_EXIST) begin
            t_raddr = TW'(r_ptr);
        end else if (a_claim) begin
            t_we = 1'b1;
        end
    end

    always_comb begin
        l_raddr = FW'(r_ptr);
        l_we    = 1'b0;
        l_waddr = FW'(r_pidx - PW'(1));
        l_wdata = l_rdata;
        if (r_state == S_SHIFT) begin
            if (r_pend && !(r_evm && r_pidx == '0)) begin
                l_we = 1'b1;
            end else if (scan_done && !r_evm) begin
                l_we    = 1'b1;
                l_waddr = FW'(r_len - LNW'(1));
                l_wdata = r_sv;
            end
        end else if (r_state == S_FILL) begin
            l_we    = 1'b1;
            l_waddr = FW'(r_len);
            l_wdata = {r_id, FW'(r_bs), FW'(blk_last)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_ptr     <= '0;
            r_end     <= '0;
            r_pend    <= 1'b0;
            r_pcnt    <= PCNT_RESET;
            r_occ     <= '0;
            r_len     <= '0;
            r_faults  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pcnt <= i_cfg_data;
            end
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            r_pend <= 1'b0;
            if (issue && (r_state == S_EXIST || r_state == S_AFILL ||
                          r_state == S_LSRCH || r_state == S_SHIFT ||
                          r_state == S_COUNT)) begin
                r_ptr  <= r_ptr + PW'(1);
                r_pend <= 1'b1;
                r_pidx <= r_ptr;
            end
            case (r_state)
                S_CLEAR: begin
                    r_ptr <= r_ptr + PW'(1);
                    if (r_ptr == PW'(TBL - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_id       <= ID_WIDTH'(i_alloc_id);
                        r_base     <= TW'(PW'(i_process_id) * PW'(TABLE_ENTRIES));
                        r_need     <= KW'(i_page_count);
                        r_status   <= ST_ALLOCATED;
                        r_bstart   <= '0;
                        r_bend     <= '0;
                        r_evicted  <= '0;
                        r_assigned <= '0;
                        r_n        <= '0;
                        r_ptr      <= '0;
                        if (PCW'(i_process_id) >= nproc) begin
                            r_end    <= '0;
                            r_status <= ST_BAD_PROC;
                            r_state  <= S_DONE;
                        end else if (i_func == FUNC_ALLOC) begin
                            r_end   <= PW'(nproc) * PW'(TABLE_ENTRIES);
                            r_state <= S_EXIST;
                        end else begin
                            r_end   <= PW'(r_len);
                            r_state <= S_LSRCH;
                        end
                    end
                end
                S_EXIST: begin
                    if (r_pend && t_used && t_owner == r_id) begin
                        r_end    <= '0;
                        r_status <= ST_EXISTS;
                        r_state  <= S_DONE;
                    end else if (scan_done) begin
                        r_ptr   <= '0;
                        r_end   <= PW'(TABLE_ENTRIES);
                        r_state <= S_AFILL;
                    end
                end
                S_AFILL: begin
                    if (r_pend) begin
                        r_need <= n_need;
                        if (a_claim) begin
                            r_assigned <= r_assigned + NW'(1);
                        end
                        if (a_stop || r_pidx == PW'(TABLE_ENTRIES - 1)) begin
                            r_end    <= '0;
                            r_status <= (n_need != '0) ? ST_PARTIAL : ST_ALLOCATED;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_LSRCH: begin
                    if (r_pend && l_id == r_id) begin
                        r_sv    <= l_rdata;
                        r_ptr   <= r_pidx + PW'(1);
                        r_end   <= PW'(r_len);
                        r_pend  <= 1'b0;
                        r_evm   <= 1'b0;
                        r_state <= S_SHIFT;
                    end else if (scan_done) begin
                        r_ptr   <= '0;
                        r_end   <= PW'(TABLE_ENTRIES);
                        r_state <= S_COUNT;
                    end
                end
                S_SHIFT: begin
                    if (r_pend && r_evm && r_pidx == '0) begin
                        r_occ <= r_occ & ~rng_mask;
                    end
                    if (scan_done) begin
                        if (r_evm) begin
                            r_len     <= r_len - LNW'(1);
                            r_evicted <= r_evicted + LNW'(1);
                            r_bs      <= '0;
                            r_f       <= '0;
                            r_state   <= S_FIND;
                        end else begin
                            r_status <= ST_HIT;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_COUNT: begin
                    if (r_pend && t_used && t_owner == r_id) begin
                        r_n <= r_n + NW'(1);
                    end
                    if (scan_done) begin
                        if (r_n == '0) begin
                            r_status <= ST_NOT_OWNED;
                            r_state  <= S_DONE;
                        end else begin
                            if (r_faults != '1) begin
                                r_faults <= r_faults + FLT_W'(1);
                            end
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_vol <= vol_c;
                    r_bs  <= '0;
                    r_f   <= '0;
                    if (CW'(vol_c) > CW'(FRAME_COUNT)) begin
                        r_status <= ST_TOO_LARGE;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (r_bs + CW'(r_vol) > CW'(FRAME_COUNT)) begin
                        if (r_len == '0) begin
                            r_status <= ST_TOO_LARGE;
                            r_state  <= S_DONE;
                        end else begin
                            r_ptr   <= '0;
                            r_end   <= PW'(r_len);
                            r_evm   <= 1'b1;
                            r_state <= S_SHIFT;
                        end
                    end else if (r_occ[r_f[FW-1:0]]) begin
                        r_bs <= r_bs + CW'(r_vol);
                        r_f  <= r_bs + CW'(r_vol);
                    end else if (r_f == blk_last) begin
                        r_state <= S_FILL;
                    end else begin
                        r_f <= r_f + CW'(1);
                    end
                end
                S_FILL: begin
                    r_occ    <= r_occ | rng_mask;
                    r_len    <= r_len + LNW'(1);
                    r_bstart <= FW'(r_bs);
                    r_bend   <= FW'(blk_last);
                    r_status <= ST_FAULT;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_o_valid || i_ready)) begin
            o_status         <= r_status;
            o_block_start    <= BLK_W'(r_bstart);
            o_block_end      <= BLK_W'(r_bend);
            o_evicted_count  <= EVC_W'(r_evicted);
            o_pages_assigned <= ASG_W'(r_assigned);
            o_fault_total    <= r_faults;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_o_valid;

endmodule

### design/ptfa_ram.sv
// ----------------------------------------------------------------------------
// ptfa_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module ptfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### design/ptfa_checker.sv
// ----------------------------------------------------------------------------
// ptfa_checker
// Port-level checks of the frame allocator result channel.
// ----------------------------------------------------------------------------
module ptfa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [ptfa_pkg::STATUS_W-1:0]  o_status,
    input logic [ptfa_pkg::BLK_W-1:0]     o_block_start,
    input logic [ptfa_pkg::BLK_W-1:0]     o_block_end,
    input logic [ptfa_pkg::EVC_W-1:0]     o_evicted_count,
    input logic [ptfa_pkg::ASG_W-1:0]     o_pages_assigned
);

    import ptfa_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("stalled result changed");

    a_block_only_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_FAULT |-> o_block_start == '0 && o_block_end == '0)
        else $error("block reported without a fault load");

    a_pages_only_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_ALLOCATED && o_status != ST_PARTIAL
        |-> o_pages_assigned == '0)
        else $error("pages assigned outside an allocate");

    a_evict_only_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_FAULT && o_status != ST_TOO_LARGE
        |-> o_evicted_count == '0)
        else $error("eviction outside a fault");

endmodule

bind page_table_frame_allocator_lru ptfa_checker u_ptfa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status         (o_status),
    .o_block_start    (o_block_start),
    .o_block_end      (o_block_end),
    .o_evicted_count  (o_evicted_count),
    .o_pages_assigned (o_pages_assigned)
);
